/* design/rspd_pkg.sv */
`timescale 1ns / 1ps

package rspd_pkg;

  localparam int unsigned RATE_W  = 16;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned OFF_W   = 7;
  localparam int unsigned IVL_W   = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned INC_W   = RATE_W + IVL_W + 1;
  localparam int unsigned ANGLE_W = 11;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RATE_THR = 2'd0;
  localparam cfg_idx_t CFG_MAG_THR  = 2'd1;
  localparam cfg_idx_t CFG_ANG_OFF  = 2'd2;

  typedef logic [1:0] event_t;
  localparam event_t EV_NONE   = 2'd0;
  localparam event_t EV_FINISH = 2'd1;
  localparam event_t EV_CATCH  = 2'd2;

  localparam logic [THR_W-1:0] RATE_THR_RST = 15'd48;
  localparam logic [THR_W-1:0] MAG_THR_RST  = 15'd16384;
  localparam logic [OFF_W-1:0] ANG_OFF_RST  = 7'd13;

  // Accumulator unit is 1/16000 degree. 16000 = 2^7 * 125; the divide by 125
  // is a multiply by ceil(2^26 / 125), exact for the 19-bit quotient input.
  localparam logic [19:0] RECIP_125 = 20'd536871;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 11'sd1023;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -11'sd1024;

  // Accumulator to whole degrees (truncated toward zero), plus offset, clamped.
  // Any accumulator beyond +-2^25 is far past the clamp, so only 26 bits divide.
  function automatic logic signed [ANGLE_W-1:0] acc_to_angle(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [OFF_W:0]   off
  );
    logic                  in_range;
    logic signed [25:0]    low;
    logic [25:0]           mag;
    logic [18:0]           y;
    logic [38:0]           prod;
    logic [11:0]           q;
    logic signed [13:0]    qs;
    logic signed [13:0]    d;
    logic signed [ANGLE_W-1:0] res;
    in_range = (acc[ACC_W-1:25] == {(ACC_W-25){acc[25]}});
    low      = acc[25:0];
    mag      = low[25] ? 26'(-low) : 26'(low);
    y        = mag[25:7];
    prod     = 39'(y) * 39'(RECIP_125);
    q        = prod[37:26];
    qs       = low[25] ? -$signed({2'b00, q}) : $signed({2'b00, q});
    d        = qs + 14'(off);
    if (!in_range) begin
      res = acc[ACC_W-1] ? ANGLE_MIN : ANGLE_MAX;
    end else if (d > 14'sd1023) begin
      res = ANGLE_MAX;
    end else if (d < -14'sd1024) begin
      res = ANGLE_MIN;
    end else begin
      res = d[ANGLE_W-1:0];
    end
    return res;
  endfunction

endpackage

/* design/rowing_stroke_phase_detector.sv */
`timescale 1ns / 1ps

// Rowing stroke phase detector. Each request carries one sensor sample and
// yields exactly one result: an event code (none, finish closed, catch
// closed), the last finish and catch angles in degrees, the last half-stroke
// and full-stroke times in milliseconds and the peak rate of the current
// stroke. A request is captured in an input register; once the result
// register is free or being taken, one pass of logic (rate times interval,
// a 40-bit saturating accumulate, a reciprocal multiply for the angle)
// updates the phase state and loads the result register. One request is
// taken every cycle while results are being taken. The threshold and
// offset registers may only be written while no request is in flight.
module rowing_stroke_phase_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  rspd_pkg::cfg_idx_t                   cfg_idx_i,
  input  logic [rspd_pkg::THR_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rspd_pkg::RATE_W-1:0]   rate_i,
  input  logic signed [rspd_pkg::RATE_W-1:0]   mag_i,
  input  logic [rspd_pkg::IVL_W-1:0]           interval_ms_i,
  input  logic [rspd_pkg::TIME_W-1:0]          now_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output rspd_pkg::event_t                     event_res_o,
  output logic signed [rspd_pkg::ANGLE_W-1:0]  finish_deg_o,
  output logic signed [rspd_pkg::ANGLE_W-1:0]  catch_deg_o,
  output logic [rspd_pkg::MS_W-1:0]            half_stroke_ms_o,
  output logic [rspd_pkg::MS_W-1:0]            stroke_ms_o,
  output logic [rspd_pkg::THR_W-1:0]           peak_rate_o
);
  import rspd_pkg::*;

  logic [THR_W-1:0] rate_thr_q, mag_thr_q;
  logic [OFF_W-1:0] ang_off_q;

  logic                     s1_valid_q;
  logic signed [RATE_W-1:0] rate_q, mag_q;
  logic [IVL_W-1:0]         ivl_q;
  logic [TIME_W-1:0]        now_q;

  logic signed [ACC_W-1:0] fin_acc_q, fin_acc_d, cat_acc_q, cat_acc_d;
  logic                    fin_armed_q, fin_armed_d, cat_armed_q, cat_armed_d;
  logic [TIME_W-1:0]       start_q, start_d;
  logic                    start_vld_q, start_vld_d;
  logic [THR_W-1:0]        peak_q, peak_d, peak_out;

  logic                      out_valid_q;
  event_t                    ev_q, ev_d;
  logic signed [ANGLE_W-1:0] fin_ang_q, fin_ang_d, cat_ang_q, cat_ang_d;
  logic [MS_W-1:0]           half_q, half_d, stroke_q, stroke_d;
  logic [THR_W-1:0]          peak_res_q;

  logic s1_adv;
  logic up, down, mag_ok;
  logic signed [RATE_W:0]  thr_s, mthr_s, rate_x, mag_x;
  logic signed [INC_W-1:0] inc;
  logic [TIME_W-1:0]       elapsed_raw;
  logic [MS_W-1:0]         elapsed;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  function automatic logic signed [ACC_W-1:0] acc_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [INC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    thr_s  = $signed({2'b00, rate_thr_q});
    mthr_s = $signed({2'b00, mag_thr_q});
    rate_x = (RATE_W+1)'(rate_q);
    mag_x  = (RATE_W+1)'(mag_q);
    up     = rate_x > thr_s;
    down   = rate_x < -thr_s;
    mag_ok = (mag_x > mthr_s) || (mag_x < -mthr_s);
    inc    = INC_W'(rate_q) * $signed({1'b0, ivl_q});

    elapsed_raw = now_q - start_q;
    elapsed     = (elapsed_raw[TIME_W-1:MS_W] != '0) ? '1 : elapsed_raw[MS_W-1:0];

    // Peak register is never negative, so only a positive rate can raise it.
    peak_d = peak_q;
    if (rate_x > $signed({2'b00, peak_q})) begin
      peak_d = rate_q[THR_W-1:0];
    end
    peak_out = peak_d;

    fin_acc_d   = fin_acc_q;
    cat_acc_d   = cat_acc_q;
    fin_armed_d = fin_armed_q || (up && mag_ok);
    cat_armed_d = cat_armed_q || (down && mag_ok);
    start_d     = start_q;
    start_vld_d = start_vld_q;
    ev_d        = EV_NONE;
    fin_ang_d   = fin_ang_q;
    cat_ang_d   = cat_ang_q;
    half_d      = half_q;
    stroke_d    = stroke_q;

    if (up && fin_armed_d) begin
      fin_acc_d = acc_add(fin_acc_q, inc);
    end else if (down && fin_armed_d) begin
      if (start_vld_q) begin
        half_d = elapsed;
      end
      fin_armed_d = 1'b0;
      fin_ang_d   = acc_to_angle(fin_acc_q, $signed({1'b0, ang_off_q}));
      fin_acc_d   = '0;
      ev_d        = EV_FINISH;
    end

    if (down && cat_armed_d) begin
      cat_acc_d = acc_add(cat_acc_q, inc);
    end else if (up && cat_armed_d) begin
      if (start_vld_q) begin
        stroke_d = elapsed;
      end
      start_d     = now_q;
      start_vld_d = 1'b1;
      cat_armed_d = 1'b0;
      cat_ang_d   = acc_to_angle(cat_acc_q, -$signed({1'b0, ang_off_q}));
      cat_acc_d   = '0;
      peak_d      = '0;
      ev_d        = EV_CATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_thr_q <= RATE_THR_RST;
      mag_thr_q  <= MAG_THR_RST;
      ang_off_q  <= ANG_OFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RATE_THR: rate_thr_q <= cfg_data_i;
        CFG_MAG_THR:  mag_thr_q  <= cfg_data_i;
        CFG_ANG_OFF:  ang_off_q  <= cfg_data_i[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rate_q <= rate_i;
      mag_q  <= mag_i;
      ivl_q  <= interval_ms_i;
      now_q  <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_acc_q   <= '0;
      cat_acc_q   <= '0;
      fin_armed_q <= 1'b1;
      cat_armed_q <= 1'b0;
      start_q     <= '0;
      start_vld_q <= 1'b0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
      ev_q        <= EV_NONE;
      fin_ang_q   <= '0;
      cat_ang_q   <= '0;
      half_q      <= '0;
      stroke_q    <= '0;
      peak_res_q  <= '0;
    end else begin
      if (s1_adv) begin
        fin_acc_q   <= fin_acc_d;
        cat_acc_q   <= cat_acc_d;
        fin_armed_q <= fin_armed_d;
        cat_armed_q <= cat_armed_d;
        start_q     <= start_d;
        start_vld_q <= start_vld_d;
        peak_q      <= peak_d;
        out_valid_q <= 1'b1;
        ev_q        <= ev_d;
        fin_ang_q   <= fin_ang_d;
        cat_ang_q   <= cat_ang_d;
        half_q      <= half_d;
        stroke_q    <= stroke_d;
        peak_res_q  <= peak_out;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = ev_q;
  assign finish_deg_o     = fin_ang_q;
  assign catch_deg_o      = cat_ang_q;
  assign half_stroke_ms_o = half_q;
  assign stroke_ms_o      = stroke_q;
  assign peak_rate_o      = peak_res_q;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rspd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTED    = 30;
  localparam int FULL_SCALE_RUN = 10;
  localparam int UNITS_PER_DEG  = 16000;
  localparam int RATE_TOP       = 32767;
  localparam int RATE_BOTTOM    = 32768;
  localparam longint SUM_MAX    = 64'sd549755813887;
  localparam longint SUM_MIN    = -SUM_MAX - 1;
  localparam cfg_idx_t CFG_SPARE = 2'd3;
  localparam logic signed [RATE_W-1:0] RATE_HI = 16'sh7FFF;
  localparam logic signed [RATE_W-1:0] RATE_LO = 16'sh8000;

  typedef enum int {RATE_UP, RATE_DOWN, RATE_QUIET} rate_class_e;

  typedef struct {
    event_t                    ev;
    logic signed [ANGLE_W-1:0] finish_deg;
    logic signed [ANGLE_W-1:0] catch_deg;
    logic [MS_W-1:0]           half_ms;
    logic [MS_W-1:0]           full_ms;
    logic [THR_W-1:0]          peak;
  } stroke_report_t;

  class stroke_tracker;
    logic [THR_W-1:0]          rate_thr;
    logic [THR_W-1:0]          mag_thr;
    logic [OFF_W-1:0]          ang_off;
    longint                    finish_sum;
    longint                    catch_sum;
    bit                        finish_armed;
    bit                        catch_armed;
    logic [TIME_W-1:0]         start_ms;
    bit                        start_seen;
    int                        peak;
    logic signed [ANGLE_W-1:0] finish_deg;
    logic signed [ANGLE_W-1:0] catch_deg;
    logic [MS_W-1:0]           half_ms;
    logic [MS_W-1:0]           full_ms;
    stroke_report_t            expected_reports[$];
    int                        errors;

    function new();
      rate_thr     = RATE_THR_RST;
      mag_thr      = MAG_THR_RST;
      ang_off      = ANG_OFF_RST;
      finish_sum   = 0;
      catch_sum    = 0;
      finish_armed = 1'b1;
      catch_armed  = 1'b0;
      start_ms     = '0;
      start_seen   = 1'b0;
      peak         = 0;
      finish_deg   = '0;
      catch_deg    = '0;
      half_ms      = '0;
      full_ms      = '0;
      errors       = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [THR_W-1:0] val);
      case (idx)
        CFG_RATE_THR: rate_thr = val;
        CFG_MAG_THR:  mag_thr = val;
        CFG_ANG_OFF:  ang_off = val[OFF_W-1:0];
        default: ;
      endcase
    endfunction

    function longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (s > SUM_MAX) return SUM_MAX;
      if (s < SUM_MIN) return SUM_MIN;
      return s;
    endfunction

    // Division truncates toward zero, then the offset is applied and clamped.
    function logic signed [ANGLE_W-1:0] degrees(longint sum, int off);
      longint d;
      d = sum / UNITS_PER_DEG + off;
      if (d > longint'(ANGLE_MAX)) return ANGLE_MAX;
      if (d < longint'(ANGLE_MIN)) return ANGLE_MIN;
      return d[ANGLE_W-1:0];
    endfunction

    function logic [MS_W-1:0] since_start(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] e;
      e = now - start_ms;
      return (e > 32'd65535) ? 16'hFFFF : e[MS_W-1:0];
    endfunction

    function void take_sample(logic signed [RATE_W-1:0] rate, logic signed [RATE_W-1:0] mag,
                              logic [IVL_W-1:0] ivl, logic [TIME_W-1:0] now);
      int             r;
      int             m;
      int             thr;
      int             mthr;
      bit             up;
      bit             down;
      bit             mag_ok;
      longint         inc;
      stroke_report_t rep;
      r      = rate;
      m      = mag;
      thr    = rate_thr;
      mthr   = mag_thr;
      up     = r > thr;
      down   = r < -thr;
      mag_ok = (m > mthr) || (m < -mthr);
      inc    = longint'(r) * longint'(ivl);
      rep.ev = EV_NONE;

      if (r > peak) peak = r;
      rep.peak = peak[THR_W-1:0];

      if (up && mag_ok) finish_armed = 1'b1;
      if (up && finish_armed) begin
        finish_sum = add_sat(finish_sum, inc);
      end else if (down && finish_armed) begin
        if (start_seen) half_ms = since_start(now);
        finish_armed = 1'b0;
        finish_deg   = degrees(finish_sum, ang_off);
        finish_sum   = 0;
        rep.ev       = EV_FINISH;
      end

      if (down && mag_ok) catch_armed = 1'b1;
      if (down && catch_armed) begin
        catch_sum = add_sat(catch_sum, inc);
      end else if (up && catch_armed) begin
        if (start_seen) full_ms = since_start(now);
        start_ms    = now;
        start_seen  = 1'b1;
        catch_armed = 1'b0;
        catch_deg   = degrees(catch_sum, -int'(ang_off));
        catch_sum   = 0;
        peak        = 0;
        rep.ev      = EV_CATCH;
      end

      rep.finish_deg = finish_deg;
      rep.catch_deg  = catch_deg;
      rep.half_ms    = half_ms;
      rep.full_ms    = full_ms;
      expected_reports.push_back(rep);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    task check_result(stroke_report_t got);
      stroke_report_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
        return;
      end
      want = expected_reports.pop_front();
      check_field("event_res", got.ev, want.ev);
      check_field("finish_deg", got.finish_deg, want.finish_deg);
      check_field("catch_deg", got.catch_deg, want.catch_deg);
      check_field("half_stroke_ms", got.half_ms, want.half_ms);
      check_field("stroke_ms", got.full_ms, want.full_ms);
      check_field("peak_rate", got.peak, want.peak);
    endtask

    function int outstanding();
      return expected_reports.size();
    endfunction

    task flag_leftovers();
      if (expected_reports.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
    endtask
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  cfg_idx_t                     cfg_idx_i;
  logic [THR_W-1:0]             cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [RATE_W-1:0]     rate_i;
  logic signed [RATE_W-1:0]     mag_i;
  logic [IVL_W-1:0]             interval_ms_i;
  logic [TIME_W-1:0]            now_ms_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  event_t                       event_res_o;
  logic signed [ANGLE_W-1:0]    finish_deg_o;
  logic signed [ANGLE_W-1:0]    catch_deg_o;
  logic [MS_W-1:0]              half_stroke_ms_o;
  logic [MS_W-1:0]              stroke_ms_o;
  logic [THR_W-1:0]             peak_rate_o;

  stroke_tracker     tracker = new();
  int                sent_count = 0;
  bit                pace_src = 1'b1;
  bit                pace_sink = 1'b1;
  int                src_burst = 0;
  int                ready_left = 0;
  int                idle_cycles = 0;
  logic [TIME_W-1:0] clock_ms;

  rowing_stroke_phase_detector DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rate_i           (rate_i),
    .mag_i            (mag_i),
    .interval_ms_i    (interval_ms_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o),
    .finish_deg_o     (finish_deg_o),
    .catch_deg_o      (catch_deg_o),
    .half_stroke_ms_o (half_stroke_ms_o),
    .stroke_ms_o      (stroke_ms_o),
    .peak_rate_o      (peak_rate_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Result side: ready runs alternate with stalls, some runs long enough to stream.
  always @(posedge clk_i) begin
    if (!pace_sink) begin
      out_ready_i <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (out_ready_i) begin
      out_ready_i <= 1'b0;
      ready_left = idle_length();
    end else begin
      out_ready_i <= 1'b1;
      ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  end

  always @(posedge clk_i) begin : monitor
    stroke_report_t got;
    bit             took_in;
    bit             took_out;
    if (rst_ni) begin
      took_in  = in_valid_i && in_ready_o;
      took_out = out_valid_o && out_ready_i;
      if (took_in) tracker.take_sample(rate_i, mag_i, interval_ms_i, now_ms_i);
      if (took_out) begin
        got.ev         = event_res_o;
        got.finish_deg = finish_deg_o;
        got.catch_deg  = catch_deg_o;
        got.half_ms    = half_stroke_ms_o;
        got.full_ms    = stroke_ms_o;
        got.peak       = peak_rate_o;
        tracker.check_result(got);
      end
      if (took_in || took_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_sample(logic signed [RATE_W-1:0] rate, logic signed [RATE_W-1:0] mag,
                             logic [IVL_W-1:0] ivl, logic [TIME_W-1:0] now);
    int gap;
    in_valid_i    <= 1'b1;
    rate_i        <= rate;
    mag_i         <= mag;
    interval_ms_i <= ivl;
    now_ms_i      <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    gap = 0;
    if (pace_src) begin
      if (src_burst > 0) src_burst--;
      else if ($urandom_range(0, 99) < 4) src_burst = $urandom_range(20, 60);
      else gap = idle_length();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [THR_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_register(idx, data);
  endtask

  // The spare index must leave every register alone; the offset carries
  // random upper bits that the block has to drop.
  task automatic configure(logic [THR_W-1:0] rate_thr, logic [THR_W-1:0] mag_thr,
                           logic [OFF_W-1:0] offset);
    write_reg(CFG_RATE_THR, rate_thr);
    write_reg(CFG_SPARE, THR_W'($urandom));
    write_reg(CFG_MAG_THR, mag_thr);
    write_reg(CFG_ANG_OFF, {(THR_W - OFF_W)'($urandom), offset});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [IVL_W-1:0] next_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return IVL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TIME_W-1:0] advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) clock_ms = $urandom;
    else if (r < 6) clock_ms += $urandom_range(60000, 200000);
    else clock_ms += $urandom_range(0, 400);
    return clock_ms;
  endfunction

  function automatic logic signed [RATE_W-1:0] pick_rate(rate_class_e kind);
    int thr;
    int lo;
    int hi;
    int v;
    thr = tracker.rate_thr;
    if (kind == RATE_UP && thr < RATE_TOP) begin
      lo = thr + 1;
      hi = ($urandom_range(0, 3) == 0) ? ((lo + 3 > RATE_TOP) ? RATE_TOP : lo + 3) : RATE_TOP;
      v  = $urandom_range(lo, hi);
      return RATE_W'(v);
    end
    if (kind == RATE_DOWN) begin
      lo = thr + 1;
      hi = ($urandom_range(0, 3) == 0) ? ((lo + 3 > RATE_BOTTOM) ? RATE_BOTTOM : lo + 3)
                                       : RATE_BOTTOM;
      v  = $urandom_range(lo, hi);
      return RATE_W'(-v);
    end
    v = $urandom_range(0, 2 * thr);
    return RATE_W'(v - thr);
  endfunction

  function automatic logic signed [RATE_W-1:0] pick_mag(bit qualifies);
    int mthr;
    int v;
    mthr = tracker.mag_thr;
    if (qualifies) begin
      if (mthr >= RATE_TOP) v = RATE_BOTTOM;
      else if ($urandom_range(0, 3) == 0) v = mthr + 1;
      else v = $urandom_range(mthr + 1, RATE_BOTTOM);
      if (v == RATE_BOTTOM || $urandom_range(0, 1) == 1) return RATE_W'(-v);
      return RATE_W'(v);
    end
    v = $urandom_range(0, 2 * mthr);
    return RATE_W'(v - mthr);
  endfunction

  // One half of a stroke; now and then a quiet sample or a missing qualifier
  // breaks it up.
  task automatic drive_run(rate_class_e dir, int len, bit arm);
    for (int i = 0; i < len; i++) begin
      rate_class_e kind;
      bit          qual;
      kind = ($urandom_range(0, 9) == 0) ? RATE_QUIET : dir;
      qual = (i == 0 && arm) || ($urandom_range(0, 3) == 0);
      send_sample(pick_rate(kind), pick_mag(qual), next_interval(), advance_clock());
    end
  endtask

  task automatic random_strokes(int count);
    int target;
    target = sent_count + count;
    while (sent_count < target) begin
      if ($urandom_range(0, 99) < 15) begin
        send_sample(RATE_W'($urandom), RATE_W'($urandom), next_interval(), advance_clock());
      end else begin
        drive_run(RATE_UP, $urandom_range(1, 6), $urandom_range(0, 4) != 0);
        drive_run(RATE_DOWN, $urandom_range(1, 6), $urandom_range(0, 4) != 0);
      end
      if ($urandom_range(0, 99) < 2) drain_results();
    end
  endtask

  task automatic directed_samples();
    send_sample(16'sd0, 16'sd0, 8'd0, 32'd0);
    // Two full-scale samples push the finish angle past the clamp.
    send_sample(RATE_HI, RATE_HI, 8'd255, 32'd100);
    send_sample(RATE_HI, 16'sd16385, 8'd255, 32'd110);
    send_sample(RATE_HI, 16'sd0, 8'd0, 32'd120);
    send_sample(RATE_LO, RATE_LO, 8'd255, 32'd200);
    send_sample(RATE_LO, 16'sd0, 8'd255, 32'd210);
    // First catch close: no stroke start yet, so the stroke time holds.
    send_sample(16'sd49, 16'sd0, 8'd10, 32'd300);
    send_sample(16'sd48, 16'sd16385, 8'd10, 32'd310);
    send_sample(-16'sd48, -16'sd16385, 8'd10, 32'd320);
    send_sample(16'sd49, 16'sd16385, 8'd1, 32'd400);
    send_sample(-16'sd49, 16'sd16384, 8'd1, 32'd70300);
    send_sample(-16'sd49, -16'sd16385, 8'd1, 32'd70310);
    send_sample(16'sd1000, -16'sd16384, 8'd7, 32'd250);
    send_sample(16'sd100, 16'sd20000, 8'd255, 32'd260);
    send_sample(-16'sd100, 16'sd0, 8'd255, 32'd1260);
    send_sample(-16'sd2000, -16'sd20000, 8'd100, 32'd1300);
    send_sample(16'sd3000, 16'sd0, 8'h55, 32'd2260);
    send_sample(16'sh5555, 16'shAAAA, 8'hAA, 32'hFFFF_FFFF);
    send_sample(16'shAAAA, 16'sh5555, 8'h55, 32'h0000_0005);
    send_sample(16'sh5555, 16'sd0, 8'd1, 32'hFFFF_FFF0);
    // Elapsed times across the timestamp wrap stay small.
    send_sample(16'sd100, 16'sd20000, 8'd1, 32'h0000_0010);
    send_sample(-16'sd100, -16'sd20000, 8'd1, 32'h0000_0020);
    send_sample(16'sd100, 16'sd0, 8'd1, 32'h0000_0040);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_RATE_THR;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    rate_i        <= '0;
    mag_i         <= '0;
    interval_ms_i <= '0;
    now_ms_i      <= '0;
    out_ready_i   <= 1'b0;
    clock_ms = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_samples();
    drain_results();
    random_strokes(110);

    // The sender holds off here until every result is back.
    drain_results();
    configure('0, '0, 7'd127);
    random_strokes(100);
    drain_results();
    configure(15'd32767, 15'd32767, 7'd0);
    random_strokes(80);

    repeat (3) begin
      drain_results();
      configure(THR_W'($urandom_range(0, 3000)), THR_W'($urandom_range(0, 32767)),
                OFF_W'($urandom_range(0, 127)));
      random_strokes(90);
    end

    // Full-scale runs with both sides always ready stream requests back to
    // back and close both phases with large angles.
    drain_results();
    configure(RATE_THR_RST, MAG_THR_RST, ANG_OFF_RST);
    pace_src  = 1'b0;
    pace_sink = 1'b0;
    repeat (FULL_SCALE_RUN) send_sample(RATE_HI, RATE_HI, 8'd255, advance_clock());
    repeat (FULL_SCALE_RUN) send_sample(RATE_LO, RATE_LO, 8'd255, advance_clock());
    send_sample(RATE_HI, 16'sd0, 8'd255, advance_clock());
    pace_src  = 1'b1;
    pace_sink = 1'b1;
    random_strokes(40);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    tracker.flag_leftovers();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
